// ===== hw/rtl/jats_pkg.sv =====
// shared types and constants for the json array to string elements splitter
package jats_pkg;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_CHAR  = 1'b1;

    localparam logic [1:0] REG_VALUE_TYPE     = 2'd0;
    localparam logic [1:0] REG_ELEMENT_LENGTH = 2'd1;
    localparam logic [1:0] REG_ELEMENT_COUNT  = 2'd2;
    localparam logic [1:0] REG_NAMED_MODE     = 2'd3;

    localparam logic [2:0] VT_STRING = 3'd0;
    localparam logic [2:0] VT_SINT   = 3'd1;
    localparam logic [2:0] VT_UINT   = 3'd2;
    localparam logic [2:0] VT_BOOL   = 3'd3;
    localparam logic [2:0] VT_REAL   = 3'd4;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_NULL    = 3'd2;
    localparam logic [2:0] ST_ILLEGAL = 3'd3;
    localparam logic [2:0] ST_LONG    = 3'd4;
    localparam logic [2:0] ST_MANY    = 3'd5;

    typedef enum logic [3:0] {
        CC_NUL,
        CC_WS,
        CC_RBRK,
        CC_COMMA,
        CC_RBRACE,
        CC_QUOTE,
        CC_MINUS,
        CC_DOT,
        CC_BSLASH,
        CC_SPCOLON,
        CC_LBRK,
        CC_BOOL,
        CC_DIGIT,
        CC_OTHER
    } char_class_t;

    typedef struct packed {
        logic        kind;
        char_class_t cls;
        logic [7:0]  ch;
    } item_t;

    typedef struct packed {
        logic [2:0] value_type;
        logic [8:0] element_length;
        logic [8:0] element_count;
        logic       named_mode;
    } cfg_t;

    typedef struct packed {
        logic       write_enable;
        logic [7:0] write_element;
        logic [7:0] write_offset;
        logic [7:0] write_byte;
        logic       done_res;
        logic       char_consumed;
        logic [2:0] status;
        logic [8:0] clear_from;
    } res_t;

endpackage

// ===== hw/rtl/json_array_to_string_elements.sv =====
// top level of the json array to string elements splitter
//   channel  dir  handshake             payload
//   s_       in   s_valid / s_ready     s_kind, s_source_char
//   m_       out  m_valid / m_ready     write, done, char_consumed, status and clear_from fields
//   apb      in   psel/penable/pready   paddr, pwdata, prdata (4 registers)
// one word per cycle unless a result stalls on m_ready; a start word passes through the back end but gives no result
// a result passes through the queue stage, then the result register
// the two-entry queue lets the front keep accepting while a result waits on m_ready
// aresetn is synchronous; registers return to their reset values, the queue empties
module json_array_to_string_elements import jats_pkg::*; #(
    parameter int MAX_ELEMENT_LENGTH = 256,
    parameter int MAX_ELEMENTS       = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_source_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_enable,
    output logic [7:0]  m_write_element,
    output logic [7:0]  m_write_offset,
    output logic [7:0]  m_write_byte,
    output logic        m_done_res,
    output logic        m_char_consumed,
    output logic [2:0]  m_status,
    output logic [8:0]  m_clear_from,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg_reg, cfg_next;
    item_t front_item;
    item_t q_head;
    logic  q_full;
    logic  q_not_empty;
    logic  q_pop;
    logic  s_take;
    res_t  res;

    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_VALUE_TYPE:     cfg_next.value_type     = pwdata[2:0];
                REG_ELEMENT_LENGTH: cfg_next.element_length = pwdata[8:0];
                REG_ELEMENT_COUNT:  cfg_next.element_count  = pwdata[8:0];
                REG_NAMED_MODE:     cfg_next.named_mode     = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_VALUE_TYPE:     prdata = {29'd0, cfg_reg.value_type};
            REG_ELEMENT_LENGTH: prdata = {23'd0, cfg_reg.element_length};
            REG_ELEMENT_COUNT:  prdata = {23'd0, cfg_reg.element_count};
            REG_NAMED_MODE:     prdata = {31'd0, cfg_reg.named_mode};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.value_type     <= VT_STRING;
            cfg_reg.element_length <= 9'd256;
            cfg_reg.element_count  <= 9'd256;
            cfg_reg.named_mode     <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !q_full;
    assign s_take  = s_valid && !q_full;

    jats_front u_front (
        .kind        (s_kind),
        .source_char (s_source_char),
        .item        (front_item)
    );

    jats_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_take),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    jats_back #(
        .MAX_ELEMENT_LENGTH (MAX_ELEMENT_LENGTH),
        .MAX_ELEMENTS       (MAX_ELEMENTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_write_enable  = res.write_enable;
    assign m_write_element = res.write_element;
    assign m_write_offset  = res.write_offset;
    assign m_write_byte    = res.write_byte;
    assign m_done_res      = res.done_res;
    assign m_char_consumed = res.char_consumed;
    assign m_status        = res.status;
    assign m_clear_from    = res.clear_from;

endmodule

// ===== hw/rtl/jats_front.sv =====
// front end: classifies each incoming character
module jats_front import jats_pkg::*; (
    input  logic       kind,
    input  logic [7:0] source_char,
    output item_t      item
);

    char_class_t cls;

    always_comb begin
        case (source_char) inside
            8'h00:                          cls = CC_NUL;
            8'h09, 8'h0a, 8'h0d:            cls = CC_WS;
            8'h5d:                          cls = CC_RBRK;
            8'h2c:                          cls = CC_COMMA;
            8'h7d:                          cls = CC_RBRACE;
            8'h22:                          cls = CC_QUOTE;
            8'h2d:                          cls = CC_MINUS;
            8'h2e:                          cls = CC_DOT;
            8'h5c:                          cls = CC_BSLASH;
            8'h20, 8'h3a:                   cls = CC_SPCOLON;
            8'h5b:                          cls = CC_LBRK;
            "t", "r", "u", "e", "f", "a", "l", "s": cls = CC_BOOL;
            [8'h30:8'h39]:                  cls = CC_DIGIT;
            default:                        cls = CC_OTHER;
        endcase
    end

    assign item.kind = kind;
    assign item.cls  = cls;
    assign item.ch   = source_char;

endmodule

// ===== hw/rtl/jats_queue.sv =====
// two-entry queue between front end and back end
module jats_queue import jats_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/jats_back.sv =====
// back end: parse state, per-character decision and result register
module jats_back import jats_pkg::*; #(
    parameter int MAX_ELEMENT_LENGTH = 256,
    parameter int MAX_ELEMENTS       = 256
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  q_valid,
    input  item_t q_item,
    output logic  q_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam int LW1 = $clog2(MAX_ELEMENT_LENGTH + 1);
    localparam int CW1 = $clog2(MAX_ELEMENTS + 1);
    localparam int CXW = (CW1 > 9) ? CW1 : 9;

    logic [1:0]     quote_count_reg, quote_count_next;
    logic           bracket_open_reg, bracket_open_next;
    logic           escape_pending_reg, escape_pending_next;
    logic [LW1-1:0] char_index_reg, char_index_next;
    logic [7:0]     element_index_reg, element_index_next;
    logic           finished_reg, finished_next;
    logic           out_valid_reg, out_valid_next;
    res_t           out_res_reg;
    res_t           res;

    logic [LW1-1:0] eff_len;
    logic [CW1-1:0] eff_cnt;
    logic [LW1-1:0] emit_off;
    logic [CXW-1:0] emit_el;
    logic [CXW-1:0] clr_ok;
    logic [CXW-1:0] ei_plus1;
    logic           can_put;
    logic           str;
    logic           is_char;

    always_comb begin
        if (cfg.element_length == 9'd0) begin
            eff_len = LW1'(1);
        end else if (32'(cfg.element_length) > MAX_ELEMENT_LENGTH) begin
            eff_len = LW1'(MAX_ELEMENT_LENGTH);
        end else begin
            eff_len = LW1'(cfg.element_length);
        end
        if (cfg.element_count == 9'd0) begin
            eff_cnt = CW1'(1);
        end else if (32'(cfg.element_count) > MAX_ELEMENTS) begin
            eff_cnt = CW1'(MAX_ELEMENTS);
        end else begin
            eff_cnt = CW1'(cfg.element_count);
        end
    end

    always_comb begin
        ei_plus1 = CXW'(element_index_reg) + CXW'(1);
        can_put  = ((LW1 + 1)'(char_index_reg) + (LW1 + 1)'(1)) < (LW1 + 1)'(eff_len);
        emit_off = (char_index_reg > eff_len - LW1'(1)) ? eff_len - LW1'(1) : char_index_reg;
        emit_el  = (CXW'(element_index_reg) > CXW'(eff_cnt) - CXW'(1)) ?
                   CXW'(eff_cnt) - CXW'(1) : CXW'(element_index_reg);
        clr_ok   = (ei_plus1 > CXW'(eff_cnt)) ? CXW'(eff_cnt) : ei_plus1;
        str      = (cfg.value_type == VT_STRING);
    end

    assign is_char = (q_item.kind == KIND_CHAR);
    assign q_pop   = q_valid && (!is_char || !out_valid_reg || out_ready);

    always_comb begin
        logic       put_req;
        logic       put_esc;
        logic       emit0;
        logic       fin;
        logic       fin_ok;
        logic [2:0] fin_st;
        logic       legal;

        put_req = 1'b0;
        put_esc = 1'b0;
        emit0   = 1'b0;
        fin     = 1'b0;
        fin_ok  = 1'b0;
        fin_st  = ST_RUN;
        legal   = 1'b0;

        res                 = '0;
        res.status          = ST_RUN;
        res.clear_from      = 9'(eff_cnt);
        quote_count_next    = quote_count_reg;
        bracket_open_next   = bracket_open_reg;
        escape_pending_next = escape_pending_reg;
        char_index_next     = char_index_reg;
        element_index_next  = element_index_reg;
        finished_next       = finished_reg;

        if (!finished_reg) begin
            if (cfg.value_type > VT_REAL) begin
                fin    = 1'b1;
                fin_st = ST_ILLEGAL;
            end else begin
                case (q_item.cls)
                    CC_NUL: begin
                        fin    = 1'b1;
                        fin_st = ST_NULL;
                    end
                    CC_WS: begin
                        res.char_consumed = 1'b1;
                    end
                    CC_RBRK: begin
                        if (bracket_open_reg && quote_count_reg == 2'd1 && str) begin
                            put_req = 1'b1;
                        end else begin
                            bracket_open_next = 1'b0;
                            if (!cfg.named_mode) begin
                                emit0  = 1'b1;
                                fin_ok = 1'b1;
                            end
                            res.char_consumed = 1'b1;
                        end
                    end
                    CC_COMMA: begin
                        if (quote_count_reg < 2'd2 && str) begin
                            if (!bracket_open_reg) begin
                                fin_ok = 1'b1;
                            end else begin
                                put_req = 1'b1;
                            end
                        end else begin
                            emit0 = 1'b1;
                            if (!bracket_open_reg) begin
                                fin_ok            = 1'b1;
                                res.char_consumed = 1'b1;
                            end else if (ei_plus1 < CXW'(eff_cnt)) begin
                                element_index_next = element_index_reg + 8'd1;
                                quote_count_next   = 2'd0;
                                char_index_next    = '0;
                                res.char_consumed  = 1'b1;
                            end else begin
                                fin    = 1'b1;
                                fin_st = ST_MANY;
                            end
                        end
                    end
                    CC_RBRACE: begin
                        if (quote_count_reg == 2'd1 && str) begin
                            put_req = 1'b1;
                        end else begin
                            emit0             = !str;
                            fin_ok            = 1'b1;
                            res.char_consumed = 1'b1;
                        end
                    end
                    CC_QUOTE: begin
                        if (!str || (!escape_pending_reg && quote_count_reg > 2'd1)) begin
                            fin    = 1'b1;
                            fin_st = ST_ILLEGAL;
                        end else if (escape_pending_reg) begin
                            escape_pending_next = 1'b0;
                            res.char_consumed   = 1'b1;
                        end else begin
                            quote_count_next  = quote_count_reg + 2'd1;
                            res.char_consumed = 1'b1;
                        end
                    end
                    CC_MINUS: begin
                        legal = str || cfg.value_type == VT_SINT || cfg.value_type == VT_REAL;
                        put_req = legal;
                        fin     = !legal;
                        fin_st  = ST_ILLEGAL;
                    end
                    CC_DOT: begin
                        legal = str || cfg.value_type == VT_REAL;
                        put_req = legal;
                        fin     = !legal;
                        fin_st  = ST_ILLEGAL;
                    end
                    CC_BSLASH: begin
                        if (!str) begin
                            fin    = 1'b1;
                            fin_st = ST_ILLEGAL;
                        end else if (!escape_pending_reg) begin
                            escape_pending_next = 1'b1;
                            res.char_consumed   = 1'b1;
                        end else begin
                            put_req = 1'b1;
                            put_esc = 1'b1;
                        end
                    end
                    CC_SPCOLON: begin
                        if (quote_count_reg == 2'd1) begin
                            put_req = 1'b1;
                        end else begin
                            res.char_consumed = 1'b1;
                        end
                    end
                    CC_LBRK: begin
                        bracket_open_next = 1'b1;
                        if (quote_count_reg != 2'd0) begin
                            put_req = 1'b1;
                        end else begin
                            res.char_consumed = 1'b1;
                        end
                    end
                    default: begin
                        if (str) begin
                            legal = (quote_count_reg != 2'd0);
                        end else if (cfg.value_type == VT_BOOL) begin
                            legal = (q_item.cls == CC_BOOL);
                        end else begin
                            legal = (q_item.cls == CC_DIGIT);
                        end
                        put_req = legal;
                        fin     = !legal;
                        fin_st  = ST_ILLEGAL;
                    end
                endcase
            end

            if (put_req) begin
                if (can_put) begin
                    res.write_enable  = 1'b1;
                    res.write_element = 8'(emit_el);
                    res.write_offset  = 8'(emit_off);
                    res.write_byte    = q_item.ch;
                    char_index_next   = char_index_reg + LW1'(1);
                    res.char_consumed = 1'b1;
                    if (put_esc) begin
                        escape_pending_next = 1'b0;
                    end
                end else begin
                    fin    = 1'b1;
                    fin_st = ST_LONG;
                end
            end
            if (emit0) begin
                res.write_enable  = 1'b1;
                res.write_element = 8'(emit_el);
                res.write_offset  = 8'(emit_off);
                res.write_byte    = 8'd0;
            end
            if (fin_ok) begin
                fin            = 1'b1;
                fin_st         = ST_OK;
                res.clear_from = 9'(clr_ok);
            end
            if (fin) begin
                res.done_res  = 1'b1;
                res.status    = fin_st;
                finished_next = 1'b1;
            end
        end

        if (!is_char) begin
            quote_count_next    = 2'd0;
            bracket_open_next   = 1'b0;
            escape_pending_next = 1'b0;
            char_index_next     = '0;
            element_index_next  = 8'd0;
            finished_next       = 1'b0;
        end
    end

    always_comb begin
        if (q_pop && is_char) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_count_reg    <= 2'd0;
            bracket_open_reg   <= 1'b0;
            escape_pending_reg <= 1'b0;
            char_index_reg     <= '0;
            element_index_reg  <= 8'd0;
            finished_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                quote_count_reg    <= quote_count_next;
                bracket_open_reg   <= bracket_open_next;
                escape_pending_reg <= escape_pending_next;
                char_index_reg     <= char_index_next;
                element_index_reg  <= element_index_next;
                finished_reg       <= finished_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && is_char) begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

`ifndef SYNTHESIS
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_res_reg.status != ST_RUN) == out_res_reg.done_res))
        else $error("status and done disagree");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !is_char) |=> (!finished_reg && char_index_reg == '0 &&
                                 element_index_reg == 8'd0 && quote_count_reg == 2'd0))
        else $error("start word did not clear parse state");

    a_after_end_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && is_char && finished_reg) |=>
            (out_valid_reg && !out_res_reg.write_enable && !out_res_reg.done_res))
        else $error("word after end produced a write or done");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |-> !(q_pop && is_char))
        else $error("result register overwritten while stalled");
`endif

endmodule
